@@ hw/rtl/lzwh_pkg.sv @@
package lzwh_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int BYTE_CODES       = 256;
    localparam int FIRST_WIDTH      = 8;
    localparam int MAX_RESULTS      = 4;
    localparam int TOTAL_W          = 25;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_DRAIN,
        ST_ADD,
        ST_ADD_SEEK,
        ST_FINAL,
        ST_PAD
    } lzwh_state_t;

    // what follows once the bit packer has drained
    typedef enum logic {
        AFT_ADD,
        AFT_PAD
    } lzwh_after_t;

endpackage

@@ hw/rtl/lzwh_in_if.sv @@
interface lzwh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

@@ hw/rtl/lzwh_out_if.sv @@
interface lzwh_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_out;
    logic [24:0] total_bytes;

    modport source (output valid, output out_byte, output last_out, output total_bytes,
                    input ready);
    modport sink   (input valid, input out_byte, input last_out, input total_bytes,
                    output ready);
endinterface

@@ hw/rtl/lzw_hashed_compressor.sv @@
// LZW compressor with variable code width (8 up to log2(DICT_ENTRIES) bits), one input
// byte per transfer on src, packed output bytes (codes MSB first) on dst. The dictionary
// lives in one synchronous RAM of DICT_ENTRIES words probed by double hashing, one probe
// per cycle. A later byte of a stream is probed until a hit, a free slot or the end of the
// walk; a hit ends there. A miss then drains its output bytes, leaves the drain and inserts
// the new entry in the table. Output stalls hold the drain and the pad. The last byte of a
// stream adds a flush of the final code, its output bytes, the drain exit, a pad step and a
// clearing pass over all DICT_ENTRIES words of the RAM before the next stream is taken. The
// same pass runs after reset. When the table is full, a miss first walks all DICT_ENTRIES
// slots, then the pass runs and the insert seeks its slot again in the fresh table.
// total_bytes counts compressed bytes of the current stream, saturating; it is meaningful
// on the transfer that carries last_out.
module lzw_hashed_compressor
    import lzwh_pkg::*;
#(
    parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    lzwh_in_if.sink           src,
    lzwh_out_if.source        dst
);

    localparam int IW = $clog2(DICT_ENTRIES);
    localparam int WW = 1 + IW + 8 + IW;
    localparam int CW = $clog2(IW + 1);
    localparam logic [IW:0] NC_FIRST = (IW + 1)'(BYTE_CODES);
    localparam logic [IW:0] NC_FULL  = (IW + 1)'(DICT_ENTRIES);

    typedef struct packed {
        logic          used;
        logic [IW-1:0] prefix;
        logic [7:0]    ext;
        logic [IW-1:0] code;
    } entry_t;

    // dictionary RAM
    logic [WW-1:0] mem [DICT_ENTRIES];
    logic [WW-1:0] rdata_reg;
    logic [IW-1:0] raddr;
    logic [IW-1:0] waddr;
    logic [WW-1:0] wdata;
    logic          we;
    entry_t        rd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rd = entry_t'(rdata_reg);

    lzwh_state_t   state_reg, state_next;
    lzwh_after_t   after_reg, after_next;
    logic          add_mode_reg, add_mode_next;
    logic          ret_add_reg, ret_add_next;
    logic          last_reg, last_next;
    logic [7:0]    x_reg, x_next;
    logic [IW-1:0] prefix_reg, prefix_next;
    logic          have_reg, have_next;
    logic [IW:0]   nc_reg, nc_next;
    logic [CW-1:0] w_reg, w_next;
    logic [23:0]   acc_reg, acc_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [2:0]    n_reg, n_next;
    logic [TOTAL_W-1:0] bytes_reg, bytes_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] step_reg, step_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic          ov_reg, ov_next;
    logic [7:0]    ob_reg, ob_next;
    logic          ol_reg, ol_next;
    logic [TOTAL_W-1:0] ot_reg, ot_next;

    function automatic logic [IW-1:0] hash_a(logic [IW-1:0] p, logic [7:0] x);
        return IW'((32'(p) << 8) ^ 32'(x));
    endfunction

    function automatic logic [IW-1:0] hash_b(logic [IW-1:0] p, logic [7:0] x);
        return IW'((32'(p) << 5) ^ (32'(x) * 32'd7)) | IW'(1);
    endfunction

    logic          out_free;
    logic          used_eff;
    logic          hit;
    logic          walk_done;
    logic [15:0]   code_mask;
    logic [23:0]   emit_acc;
    logic [4:0]    emit_cnt;
    logic [TOTAL_W-1:0] bytes_inc;
    entry_t        new_entry;

    assign out_free  = !ov_reg || dst.ready;
    assign used_eff  = (idx_reg < IW'(BYTE_CODES)) || rd.used;
    assign hit       = (idx_reg >= IW'(BYTE_CODES)) && rd.used
                       && (rd.prefix == prefix_reg) && (rd.ext == x_reg);
    // the odd step visits every slot once; the next probe back at the start ends the walk
    assign walk_done = ((idx_reg + step_reg) == hash_a(prefix_reg, x_reg));
    assign code_mask = (16'd1 << w_reg) - 16'd1;
    assign emit_acc  = (acc_reg << w_reg) | 24'(16'(prefix_reg) & code_mask);
    assign emit_cnt  = cnt_reg + 5'(w_reg);
    assign bytes_inc = (bytes_reg == {TOTAL_W{1'b1}}) ? bytes_reg : bytes_reg + 1'b1;

    always_comb
    begin
        new_entry.used   = 1'b1;
        new_entry.prefix = prefix_reg;
        new_entry.ext    = x_reg;
        new_entry.code   = nc_reg[IW-1:0];
    end

    assign src.ready       = (state_reg == ST_IDLE);
    assign dst.valid       = ov_reg;
    assign dst.out_byte    = ob_reg;
    assign dst.last_out    = ol_reg;
    assign dst.total_bytes = ot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            after_reg    <= AFT_ADD;
            add_mode_reg <= 1'b0;
            ret_add_reg  <= 1'b0;
            last_reg     <= 1'b0;
            prefix_reg   <= '0;
            have_reg     <= 1'b0;
            nc_reg       <= NC_FIRST;
            w_reg        <= CW'(FIRST_WIDTH);
            acc_reg      <= '0;
            cnt_reg      <= '0;
            n_reg        <= '0;
            bytes_reg    <= '0;
            clr_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            after_reg    <= after_next;
            add_mode_reg <= add_mode_next;
            ret_add_reg  <= ret_add_next;
            last_reg     <= last_next;
            prefix_reg   <= prefix_next;
            have_reg     <= have_next;
            nc_reg       <= nc_next;
            w_reg        <= w_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            bytes_reg    <= bytes_next;
            clr_reg      <= clr_next;
            ov_reg       <= ov_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        idx_reg  <= idx_next;
        step_reg <= step_next;
        ob_reg   <= ob_next;
        ol_reg   <= ol_next;
        ot_reg   <= ot_next;
    end

    always_comb
    begin
        logic commit;
        logic stream_end;
        commit        = 1'b0;
        stream_end    = 1'b0;
        state_next    = state_reg;
        after_next    = after_reg;
        add_mode_next = add_mode_reg;
        ret_add_next  = ret_add_reg;
        last_next     = last_reg;
        x_next        = x_reg;
        prefix_next   = prefix_reg;
        have_next     = have_reg;
        nc_next       = nc_reg;
        w_next        = w_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        bytes_next    = bytes_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        clr_next      = clr_reg;
        ov_next       = dst.ready ? 1'b0 : ov_reg;
        ob_next       = ob_reg;
        ol_next       = ol_reg;
        ot_next       = ot_reg;
        raddr         = idx_reg + step_reg;
        waddr         = idx_reg;
        wdata         = WW'(new_entry);
        we            = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {IW{1'b1}})
                begin
                    if (ret_add_reg)
                    begin
                        nc_next    = NC_FIRST;
                        w_next     = CW'(FIRST_WIDTH);
                        state_next = ST_ADD_SEEK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_IDLE:
            begin
                raddr = hash_a(prefix_reg, src.in_byte);
                if (src.valid)
                begin
                    x_next    = src.in_byte;
                    last_next = src.last_in;
                    n_next    = '0;
                    if (!have_reg)
                    begin
                        prefix_next = IW'(src.in_byte);
                        have_next   = 1'b1;
                        state_next  = src.last_in ? ST_FINAL : ST_IDLE;
                    end
                    else
                    begin
                        idx_next      = hash_a(prefix_reg, src.in_byte);
                        step_next     = hash_b(prefix_reg, src.in_byte);
                        add_mode_next = 1'b0;
                        state_next    = ST_PROBE;
                    end
                end
            end

            ST_PROBE:
            begin
                idx_next = idx_reg + step_reg;
                if (add_mode_reg)
                begin
                    if (!used_eff)
                    begin
                        commit = 1'b1;
                    end
                end
                else if (hit)
                begin
                    prefix_next = rd.code;
                    state_next  = last_reg ? ST_FINAL : ST_IDLE;
                end
                else if (!used_eff || walk_done)
                begin
                    // miss: send the prefix code, insert at this free slot later
                    // (a full table ends the walk with no free slot; the insert clears it)
                    idx_next   = idx_reg;
                    acc_next   = emit_acc;
                    cnt_next   = emit_cnt;
                    after_next = AFT_ADD;
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (cnt_reg >= 5'd8)
                begin
                    if (n_reg == 3'(MAX_RESULTS))
                    begin
                        cnt_next = cnt_reg - 5'd8;
                    end
                    else if (out_free)
                    begin
                        ov_next    = 1'b1;
                        ob_next    = 8'(acc_reg >> (cnt_reg - 5'd8));
                        ol_next    = (after_reg == AFT_PAD)
                                     && ((n_reg == 3'(MAX_RESULTS - 1)) || (cnt_reg == 5'd8));
                        ot_next    = bytes_inc;
                        bytes_next = bytes_inc;
                        n_next     = n_reg + 1'b1;
                        cnt_next   = cnt_reg - 5'd8;
                    end
                end
                else
                begin
                    state_next = (after_reg == AFT_ADD) ? ST_ADD : ST_PAD;
                end
            end

            ST_ADD:
            begin
                if (nc_reg >= NC_FULL)
                begin
                    clr_next     = '0;
                    ret_add_next = 1'b1;
                    state_next   = ST_CLEAR;
                end
                else
                begin
                    commit = 1'b1;
                end
            end

            ST_ADD_SEEK:
            begin
                raddr         = hash_a(prefix_reg, x_reg);
                idx_next      = hash_a(prefix_reg, x_reg);
                step_next     = hash_b(prefix_reg, x_reg);
                add_mode_next = 1'b1;
                state_next    = ST_PROBE;
            end

            ST_FINAL:
            begin
                acc_next   = emit_acc;
                cnt_next   = emit_cnt;
                after_next = AFT_PAD;
                state_next = ST_DRAIN;
            end

            ST_PAD:
            begin
                if ((cnt_reg != 5'd0) && (n_reg != 3'(MAX_RESULTS)))
                begin
                    if (out_free)
                    begin
                        ov_next    = 1'b1;
                        ob_next    = 8'(acc_reg << (5'd8 - cnt_reg));
                        ol_next    = 1'b1;
                        ot_next    = bytes_inc;
                        stream_end = 1'b1;
                    end
                end
                else
                begin
                    stream_end = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (commit)
        begin
            we          = 1'b1;
            waddr       = idx_reg;
            nc_next     = nc_reg + 1'b1;
            w_next      = ((nc_reg >> w_reg) != '0) ? w_reg + 1'b1 : w_reg;
            prefix_next = IW'(x_reg);
            state_next  = last_reg ? ST_FINAL : ST_IDLE;
        end

        if (stream_end)
        begin
            prefix_next  = '0;
            have_next    = 1'b0;
            nc_next      = NC_FIRST;
            w_next       = CW'(FIRST_WIDTH);
            acc_next     = '0;
            cnt_next     = '0;
            bytes_next   = '0;
            clr_next     = '0;
            ret_add_next = 1'b0;
            state_next   = ST_CLEAR;
        end
    end

    // code width stays within the first width and the table index width
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        (w_reg >= CW'(FIRST_WIDTH)) && (32'(w_reg) <= IW))
        else $error("code width out of range");

    // the code counter never passes the table size
    a_nc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nc_reg <= NC_FULL)
        else $error("next code beyond table size");

    // the packer is drained below one byte whenever a new byte may enter
    a_packer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        src.ready |-> (cnt_reg < 5'd8))
        else $error("packer holds a full byte while idle");

    // a byte taken from the packer lands in the output register
    a_drain_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && cnt_reg >= 5'd8 && n_reg != 3'(MAX_RESULTS) && out_free)
        |=> ov_reg)
        else $error("drained byte lost");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import lzwh_pkg::*;

    localparam int ENTRIES   = DICT_ENTRIES_DEF;
    localparam int MASK      = ENTRIES - 1;
    localparam int CYCLE_CAP = 3000000;
    localparam logic [24:0] COUNT_MAX = 25'h1FFFFFF;

    logic clk;
    logic rst_n;

    lzwh_in_if  in_ch ();
    lzwh_out_if out_ch ();

    lzw_hashed_compressor #(.DICT_ENTRIES(ENTRIES)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (in_ch.sink),
        .dst   (out_ch.source)
    );

    // One raw byte to send. hold_first makes the sender wait for the
    // output side to drain before offering this byte.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold_first;
    } raw_item_t;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic [24:0] total;
    } packed_byte_t;

    raw_item_t    raw_pending[$];
    packed_byte_t packed_expected[$];

    int  error_count;
    int  cycle_count;
    bit  in_taken;

    // Shadow of the dictionary and the bit packer.
    logic [11:0] dict_prefix [ENTRIES];
    logic [7:0]  dict_ext    [ENTRIES];
    logic [12:0] dict_code   [ENTRIES];
    bit          dict_used   [ENTRIES];
    int          cur_prefix;
    int          next_free;
    int          width;
    int          accum;
    int          pend_bits;
    logic [24:0] byte_count;
    bit          stream_open;
    logic [7:0]  step_bytes[$];

    function automatic void dict_reset();
        for (int i = 0; i < ENTRIES; i++)
        begin
            dict_prefix[i] = '0;
            dict_ext[i]    = (i < BYTE_CODES) ? i[7:0] : 8'd0;
            dict_code[i]   = (i < BYTE_CODES) ? i[12:0] : 13'd0;
            dict_used[i]   = (i < BYTE_CODES);
        end
        next_free = BYTE_CODES;
        width     = FIRST_WIDTH;
    endfunction

    function automatic void stream_reset();
        dict_reset();
        cur_prefix  = 0;
        accum       = 0;
        pend_bits   = 0;
        byte_count  = 0;
        stream_open = 0;
    endfunction

    function automatic int probe_start(int p, int x);
        return ((p << 8) ^ x) & MASK;
    endfunction

    function automatic int probe_step(int p, int x);
        return (((p << 5) ^ (x * 7)) & MASK) | 1;
    endfunction

    // returns the code on a hit, -1 on a miss; byte slots never match
    function automatic int dict_lookup(int p, int x);
        int a;
        int b;
        int idx;
        a = probe_start(p, x);
        b = probe_step(p, x);
        for (int i = 0; i < ENTRIES; i++)
        begin
            idx = (a + i * b) & MASK;
            if (!dict_used[idx])
                return -1;
            if (idx >= BYTE_CODES && dict_prefix[idx] == p && dict_ext[idx] == x)
                return dict_code[idx];
        end
        return -1;
    endfunction

    function automatic void dict_insert(int p, int x);
        int a;
        int b;
        int idx;
        if (next_free >= ENTRIES)
            dict_reset();
        if (next_free >= (1 << width))
            width++;
        a = probe_start(p, x);
        b = probe_step(p, x);
        for (int i = 0; i < ENTRIES; i++)
        begin
            idx = (a + i * b) & MASK;
            if (!dict_used[idx])
            begin
                dict_prefix[idx] = 12'(p);
                dict_ext[idx]    = 8'(x);
                dict_code[idx]   = 13'(next_free);
                dict_used[idx]   = 1;
                next_free++;
                return;
            end
        end
    endfunction

    function automatic void pack_code(int code, int w);
        int acc;
        int total;
        acc   = (accum << w) | (code & ((1 << w) - 1));
        total = pend_bits + w;
        while (total >= 8)
        begin
            total -= 8;
            step_bytes.push_back(8'((acc >> total) & 8'hFF));
        end
        accum     = acc & ((1 << total) - 1);
        pend_bits = total;
    endfunction

    // Expected output bytes caused by one accepted raw byte.
    function automatic void compress_byte(logic [7:0] x, logic last);
        int hit;
        int n;
        packed_byte_t pb;
        step_bytes.delete();
        if (!stream_open)
        begin
            cur_prefix  = x;
            stream_open = 1;
        end
        else
        begin
            hit = dict_lookup(cur_prefix, x);
            if (hit >= 0)
                cur_prefix = hit;
            else
            begin
                pack_code(cur_prefix, width);
                dict_insert(cur_prefix, x);
                cur_prefix = x;
            end
        end
        if (last)
        begin
            pack_code(cur_prefix, width);
            if (pend_bits > 0)
                step_bytes.push_back(8'((accum << (8 - pend_bits)) & 8'hFF));
            accum     = 0;
            pend_bits = 0;
        end
        n = (step_bytes.size() > MAX_RESULTS) ? MAX_RESULTS : step_bytes.size();
        for (int k = 0; k < n; k++)
        begin
            if (byte_count < COUNT_MAX)
                byte_count++;
            pb.data  = step_bytes[k];
            pb.last  = last && (k == n - 1);
            pb.total = byte_count;
            packed_expected.push_back(pb);
        end
        if (last)
            stream_reset();
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    // mostly back to back, sometimes a few cycles, rarely a long stall
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic queue_byte(input logic [7:0] d, input logic l, input bit h = 0);
        raw_item_t it;
        it.data       = d;
        it.last       = l;
        it.hold_first = h;
        raw_pending.push_back(it);
    endtask

    task automatic queue_stream(input int len, input int alphabet, input bit h = 0);
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            if (alphabet >= 256)
                queue_byte(8'($urandom_range(0, 255)), i == len - 1, h && i == len / 2);
            else
                queue_byte(base + 8'($urandom_range(0, alphabet - 1)), i == len - 1,
                           h && i == len / 2);
        end
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Sender: after a transfer, the next byte is offered at a falling edge once its random gap has run out.
    int send_gap;
    initial
    begin
        in_ch.valid   = 0;
        in_ch.in_byte = 0;
        in_ch.last_in = 0;
        send_gap      = 0;
    end

    always @(negedge clk)
    begin
        bit just_sent;
        just_sent = in_taken;
        if (in_taken)
        begin
            in_taken = 0;
            void'(raw_pending.pop_front());
            send_gap = pick_gap();
        end
        if (!rst_n || raw_pending.size() == 0)
            in_ch.valid <= 0;
        else if (!in_ch.valid || just_sent)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 0;
            end
            else if (!raw_pending[0].hold_first || packed_expected.size() == 0)
            begin
                in_ch.in_byte <= raw_pending[0].data;
                in_ch.last_in <= raw_pending[0].last;
                in_ch.valid   <= 1;
            end
            else
                in_ch.valid <= 0;
        end
    end

    // Receiver: random backpressure, changed at the falling edge.
    int stall_left;
    initial
    begin
        out_ch.ready = 0;
        stall_left   = 0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 0;
        end
        else
        begin
            out_ch.ready <= 1;
            stall_left = pick_gap();
        end
    end

    // Monitor: transfers seen at the rising edge feed the predictor and the checker.
    packed_byte_t want;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            in_taken = 1;
            compress_byte(in_ch.in_byte, in_ch.last_in);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (packed_expected.size() == 0)
                report_mismatch("unexpected byte", out_ch.out_byte, 0);
            else
            begin
                want = packed_expected.pop_front();
                if (out_ch.out_byte !== want.data)
                    report_mismatch("out_byte", out_ch.out_byte, want.data);
                if (out_ch.last_out !== want.last)
                    report_mismatch("last_out", out_ch.last_out, want.last);
                if (out_ch.total_bytes !== want.total)
                    report_mismatch("total_bytes", out_ch.total_bytes, want.total);
            end
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        in_taken    = 0;
        stream_reset();
        rst_n = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: one-byte streams at both extremes
        queue_byte(8'h00, 1);
        queue_byte(8'hFF, 1);
        // a run of one value: hits extend the prefix
        for (int i = 0; i < 9; i++)
            queue_byte(8'h41, i == 8);
        // alternating extremes
        for (int i = 0; i < 8; i++)
            queue_byte((i % 2) ? 8'hFF : 8'h00, i == 7);
        // two bytes, second a miss
        queue_byte(8'hAA, 0);
        queue_byte(8'h55, 1);

        // random streams, small alphabets to get repeats, some full range
        for (int s = 0; s < 24; s++)
            queue_stream($urandom_range(1, 18), ($urandom_range(0, 3) == 0) ? 256 :
                         $urandom_range(1, 4), s == 10);
        // a longer full-range stream, paused once mid-stream
        queue_stream(30, 256, 1);
        for (int s = 0; s < 5; s++)
            queue_stream($urandom_range(1, 12), $urandom_range(1, 256));

        wait (raw_pending.size() == 0);
        wait (packed_expected.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
